[rtl/jsu_pkg.sv]
package jsu_pkg;

   // Escape decoder phase: plain text, after a backslash, or waiting on a \u hex digit
   typedef enum logic [2:0] {
      PH_TEXT = 3'd0,
      PH_ESC  = 3'd1,
      PH_HEX1 = 3'd2,
      PH_HEX2 = 3'd3,
      PH_HEX3 = 3'd4,
      PH_HEX4 = 3'd5
   } phase_type;

   // Input transfer payload
   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
   } req_type;

   // Result transfer payload
   typedef struct packed {
      logic       byte_valid;
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_end;
      logic       bad_escape;
   } rsp_type;

   // Group of up to three results caused by one input byte
   typedef struct packed {
      logic [1:0] count;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic       str_end;
      logic       bad;
   } burst_type;

   // Characters of interest
   localparam logic [7:0] CHR_BSLASH  = 8'h5c;
   localparam logic [7:0] CHR_LOWER_B = 8'h62;
   localparam logic [7:0] CHR_LOWER_F = 8'h66;
   localparam logic [7:0] CHR_LOWER_N = 8'h6e;
   localparam logic [7:0] CHR_LOWER_R = 8'h72;
   localparam logic [7:0] CHR_LOWER_T = 8'h74;
   localparam logic [7:0] CHR_LOWER_U = 8'h75;

   // Control bytes for the short escapes
   localparam logic [7:0] CTL_BS = 8'h08;
   localparam logic [7:0] CTL_FF = 8'h0c;
   localparam logic [7:0] CTL_LF = 8'h0a;
   localparam logic [7:0] CTL_CR = 8'h0d;
   localparam logic [7:0] CTL_HT = 8'h09;

   // UTF-8 encoding limits and lead/continuation marks
   localparam logic [15:0] UTF8_MAX1 = 16'h007f;
   localparam logic [15:0] UTF8_MAX2 = 16'h07ff;
   localparam logic [7:0]  UTF8_LEAD2 = 8'hc0;
   localparam logic [7:0]  UTF8_LEAD3 = 8'he0;
   localparam logic [7:0]  UTF8_CONT  = 8'h80;

   // Hex digit value in the low four bits; bit 4 set marks a non-hex character
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = 5'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = 5'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = 5'(c - 8'h57);
      end
      return v;
   endfunction

endpackage

[rtl/jsu_decode.sv]
module jsu_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  jsu_pkg::req_type  req,
   output jsu_pkg::burst_type burst
);

   jsu_pkg::phase_type phase_ff, phase_in;
   logic [11:0]        acc_ff, acc_in;
   logic               err_ff, err_in;

   logic [7:0]  c;
   logic        last;
   logic [4:0]  d;
   logic [15:0] code;

   assign c    = req.in_byte;
   assign last = req.last_byte;
   assign d    = jsu_pkg::hex_value(c);
   assign code = {acc_ff, d[3:0]};

   // Decode one byte against the escape state
   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      err_in   = err_ff;
      burst    = '0;

      if (!err_ff) begin
         case (phase_ff)
            jsu_pkg::PH_ESC: begin
               phase_in = jsu_pkg::PH_TEXT;
               burst.count = 2'd1;
               case (c)
                  jsu_pkg::CHR_LOWER_B: burst.byte0 = jsu_pkg::CTL_BS;
                  jsu_pkg::CHR_LOWER_F: burst.byte0 = jsu_pkg::CTL_FF;
                  jsu_pkg::CHR_LOWER_N: burst.byte0 = jsu_pkg::CTL_LF;
                  jsu_pkg::CHR_LOWER_R: burst.byte0 = jsu_pkg::CTL_CR;
                  jsu_pkg::CHR_LOWER_T: burst.byte0 = jsu_pkg::CTL_HT;
                  jsu_pkg::CHR_LOWER_U: begin
                     burst.count = 2'd0;
                     phase_in    = jsu_pkg::PH_HEX1;
                     acc_in      = '0;
                     if (last) err_in = 1'b1;
                  end
                  default: burst.byte0 = c;
               endcase
            end
            jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3: begin
               if (d[4]) begin
                  err_in = 1'b1;
               end else begin
                  acc_in   = {acc_ff[7:0], d[3:0]};
                  phase_in = jsu_pkg::phase_type'(phase_ff + 3'd1);
                  if (last) err_in = 1'b1;
               end
            end
            jsu_pkg::PH_HEX4: begin
               if (d[4]) begin
                  err_in = 1'b1;
               end else begin
                  phase_in = jsu_pkg::PH_TEXT;
                  acc_in   = '0;
                  // Encode the code point as UTF-8
                  if (code <= jsu_pkg::UTF8_MAX1) begin
                     burst.count = 2'd1;
                     burst.byte0 = code[7:0];
                  end else if (code <= jsu_pkg::UTF8_MAX2) begin
                     burst.count = 2'd2;
                     burst.byte0 = jsu_pkg::UTF8_LEAD2 | {3'b000, code[10:6]};
                     burst.byte1 = jsu_pkg::UTF8_CONT | {2'b00, code[5:0]};
                  end else begin
                     burst.count = 2'd3;
                     burst.byte0 = jsu_pkg::UTF8_LEAD3 | {4'b0000, code[15:12]};
                     burst.byte1 = jsu_pkg::UTF8_CONT | {2'b00, code[11:6]};
                     burst.byte2 = jsu_pkg::UTF8_CONT | {2'b00, code[5:0]};
                  end
               end
            end
            default: begin
               phase_in = jsu_pkg::PH_TEXT;
               if (c == jsu_pkg::CHR_BSLASH && !last) begin
                  phase_in = jsu_pkg::PH_ESC;
               end else begin
                  burst.count = 2'd1;
                  burst.byte0 = c;
               end
            end
         endcase
      end

      // Drop bytes after an error; the final byte yields the error result alone
      if (err_in) begin
         burst = '0;
         if (last) begin
            burst.count = 2'd1;
            burst.bad   = 1'b1;
         end
      end

      burst.str_end = last;

      // Return to plain text at the end of every string
      if (last) begin
         phase_in = jsu_pkg::PH_TEXT;
         acc_in   = '0;
         err_in   = 1'b0;
      end
   end

   // Advance the escape state on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= jsu_pkg::PH_TEXT;
         acc_ff   <= '0;
         err_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         err_ff   <= err_in;
      end
   end

endmodule

[rtl/jsu_emit.sv]
module jsu_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  jsu_pkg::burst_type burst,
   output logic               free,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output jsu_pkg::rsp_type   rsp_data
);

   logic [1:0] cnt_ff, cnt_in;
   logic [7:0] b0_ff, b0_in;
   logic [7:0] b1_ff, b1_in;
   logic [7:0] b2_ff, b2_in;
   logic       end_ff, end_in;
   logic       bad_ff, bad_in;
   logic       xfer;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign xfer      = rsp_valid && !rsp_stall;
   // Room for a new group once the last held result leaves
   assign free      = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && !rsp_stall);

   // Present the head of the held group
   always_comb begin
      rsp_data.byte_valid = !bad_ff;
      rsp_data.out_byte   = b0_ff;
      rsp_data.run_last   = (cnt_ff == 2'd1);
      rsp_data.string_end = (cnt_ff == 2'd1) && end_ff;
      rsp_data.bad_escape = bad_ff;
   end

   // Load a new group, or shift the held one on each output transfer
   always_comb begin
      cnt_in = cnt_ff;
      b0_in  = b0_ff;
      b1_in  = b1_ff;
      b2_in  = b2_ff;
      end_in = end_ff;
      bad_in = bad_ff;
      if (load) begin
         cnt_in = burst.count;
         b0_in  = burst.byte0;
         b1_in  = burst.byte1;
         b2_in  = burst.byte2;
         end_in = burst.str_end;
         bad_in = burst.bad;
      end else if (xfer) begin
         cnt_in = cnt_ff - 2'd1;
         b0_in  = b1_ff;
         b1_in  = b2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      b0_ff  <= b0_in;
      b1_ff  <= b1_in;
      b2_ff  <= b2_in;
      end_ff <= end_in;
      bad_ff <= bad_in;
   end

endmodule

[rtl/json_string_unescape_utf8.sv]
// JSON string body unescaper. Raw bytes of an escaped string body arrive one per
// transfer on the req_ channel with a last_byte mark; decoded bytes leave one per
// transfer on the rsp_ channel. Short escapes give control bytes, \u with four hex
// digits gives one to three UTF-8 bytes, a lone trailing backslash is passed as is.
// A bad or truncated \u escape drops the rest of the string and ends it with one
// result carrying bad_escape. An input byte is taken every cycle while the output
// register is empty or its last held result leaves; a byte causing two or three
// results holds the input while the output register drains them one per cycle
// when rsp_stall is low. Results appear in the cycle after their byte is taken.
module json_string_unescape_utf8 (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  jsu_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output jsu_pkg::rsp_type rsp_data
);

   jsu_pkg::burst_type burst;
   logic               accept;
   logic               free;

   assign req_stall = !free;
   assign accept    = req_valid && free;

   jsu_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .burst  (burst)
   );

   // Load only groups that hold at least one result
   jsu_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (accept && burst.count != 2'd0),
      .burst     (burst),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[sim/unescape_checker.sv]
`timescale 1ns / 1ps

module unescape_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  jsu_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  jsu_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               pending_count,
   output int               checked_count
);

   // Decoded bytes still owed by the block, oldest first
   jsu_pkg::rsp_type decoded_q[$];

   // Own copy of the unescaper state
   jsu_pkg::phase_type esc_phase;
   logic [11:0]        hex_digits;
   logic               in_error;

   // Value of one hex character; bit 4 flags anything else
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
      if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
      if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
      return 5'h10;
   endfunction

   function automatic jsu_pkg::rsp_type decoded(input logic [7:0] b);
      jsu_pkg::rsp_type r;
      r            = '0;
      r.byte_valid = 1'b1;
      r.out_byte   = b;
      return r;
   endfunction

   // Work out the decoded bytes caused by one raw byte and queue them
   task automatic decode_raw_byte(input jsu_pkg::req_type item);
      jsu_pkg::rsp_type res [3];
      int               n;
      logic [7:0]       c;
      logic [4:0]       d;
      logic [15:0]      code;
      c = item.in_byte;
      n = 0;
      for (int i = 0; i < 3; i++) res[i] = '0;

      if (!in_error) begin
         case (esc_phase)
            jsu_pkg::PH_ESC: begin
               esc_phase = jsu_pkg::PH_TEXT;
               case (c)
                  jsu_pkg::CHR_LOWER_B: begin res[0] = decoded(jsu_pkg::CTL_BS); n = 1; end
                  jsu_pkg::CHR_LOWER_F: begin res[0] = decoded(jsu_pkg::CTL_FF); n = 1; end
                  jsu_pkg::CHR_LOWER_N: begin res[0] = decoded(jsu_pkg::CTL_LF); n = 1; end
                  jsu_pkg::CHR_LOWER_R: begin res[0] = decoded(jsu_pkg::CTL_CR); n = 1; end
                  jsu_pkg::CHR_LOWER_T: begin res[0] = decoded(jsu_pkg::CTL_HT); n = 1; end
                  jsu_pkg::CHR_LOWER_U: begin
                     esc_phase  = jsu_pkg::PH_HEX1;
                     hex_digits = '0;
                     if (item.last_byte) in_error = 1'b1;
                  end
                  default: begin res[0] = decoded(c); n = 1; end
               endcase
            end
            jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3, jsu_pkg::PH_HEX4: begin
               d = hex_nibble(c);
               if (d[4]) begin
                  in_error = 1'b1;
               end else if (esc_phase == jsu_pkg::PH_HEX4) begin
                  // Encode the code point as UTF-8
                  code = {hex_digits, d[3:0]};
                  if (code <= jsu_pkg::UTF8_MAX1) begin
                     res[0] = decoded(code[7:0]);
                     n = 1;
                  end else if (code <= jsu_pkg::UTF8_MAX2) begin
                     res[0] = decoded(jsu_pkg::UTF8_LEAD2 | {3'b000, code[10:6]});
                     res[1] = decoded(jsu_pkg::UTF8_CONT | {2'b00, code[5:0]});
                     n = 2;
                  end else begin
                     res[0] = decoded(jsu_pkg::UTF8_LEAD3 | {4'b0000, code[15:12]});
                     res[1] = decoded(jsu_pkg::UTF8_CONT | {2'b00, code[11:6]});
                     res[2] = decoded(jsu_pkg::UTF8_CONT | {2'b00, code[5:0]});
                     n = 3;
                  end
                  esc_phase  = jsu_pkg::PH_TEXT;
                  hex_digits = '0;
               end else begin
                  hex_digits = {hex_digits[7:0], d[3:0]};
                  esc_phase  = jsu_pkg::phase_type'(esc_phase + 3'd1);
                  if (item.last_byte) in_error = 1'b1;
               end
            end
            default: begin
               // Plain text; a backslash on the final byte stands for itself
               esc_phase = jsu_pkg::PH_TEXT;
               if (c == jsu_pkg::CHR_BSLASH && !item.last_byte) begin
                  esc_phase = jsu_pkg::PH_ESC;
               end else begin
                  res[0] = decoded(c);
                  n = 1;
               end
            end
         endcase
      end

      // Drop bytes after a bad escape; the final byte gives the error result
      if (in_error) begin
         n = 0;
         if (item.last_byte) begin
            res[0]            = '0;
            res[0].bad_escape = 1'b1;
            n = 1;
         end
      end

      if (n > 0) begin
         res[n-1].run_last = 1'b1;
         if (item.last_byte) res[n-1].string_end = 1'b1;
      end
      for (int i = 0; i < n; i++) decoded_q.push_back(res[i]);

      if (item.last_byte) begin
         esc_phase  = jsu_pkg::PH_TEXT;
         hex_digits = '0;
         in_error   = 1'b0;
      end
   endtask

   // Predict on each input transfer, compare on each result transfer
   always @(posedge clock) begin
      jsu_pkg::rsp_type want;
      if (reset) begin
         esc_phase      = jsu_pkg::PH_TEXT;
         hex_digits     = '0;
         in_error       = 1'b0;
         mismatch_count = 0;
         checked_count  = 0;
         decoded_q.delete();
      end else begin
         if (req_valid && !req_stall) decode_raw_byte(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (decoded_q.size() == 0) begin
               $error("unexpected result transfer: out_byte %h", rsp_data.out_byte);
               mismatch_count++;
            end else begin
               want = decoded_q.pop_front();
               checked_count++;
               if (rsp_data.byte_valid !== want.byte_valid) begin
                  $error("byte_valid: expected %0d, actual %0d",
                         want.byte_valid, rsp_data.byte_valid);
                  mismatch_count++;
               end
               if (rsp_data.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %h, actual %h",
                         want.out_byte, rsp_data.out_byte);
                  mismatch_count++;
               end
               if (rsp_data.run_last !== want.run_last) begin
                  $error("run_last: expected %0d, actual %0d",
                         want.run_last, rsp_data.run_last);
                  mismatch_count++;
               end
               if (rsp_data.string_end !== want.string_end) begin
                  $error("string_end: expected %0d, actual %0d",
                         want.string_end, rsp_data.string_end);
                  mismatch_count++;
               end
               if (rsp_data.bad_escape !== want.bad_escape) begin
                  $error("bad_escape: expected %0d, actual %0d",
                         want.bad_escape, rsp_data.bad_escape);
                  mismatch_count++;
               end
            end
         end
      end
      pending_count = decoded_q.size();
   end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;

   localparam int TOTAL_BYTES = 420;
   localparam int IDLE_LIMIT  = 2000;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   jsu_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   jsu_pkg::rsp_type rsp_data;

   int mismatches;
   int pending;
   int checked;

   // Raw byte stream, built up front and then sent in bursts
   jsu_pkg::req_type raw_q[$];
   int               string_total;
   int               pause_at = -1;
   int               idle_cycles = 0;

   json_string_unescape_utf8 u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   unescape_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatches),
      .pending_count  (pending),
      .checked_count  (checked)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic push_byte(input logic [7:0] b, input logic ends);
      jsu_pkg::req_type item;
      item.in_byte   = b;
      item.last_byte = ends;
      raw_q.push_back(item);
      if (ends) string_total++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
   endtask

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
   endfunction

   // Hex character for a nibble, either case at random
   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'h30 + v;
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 8'd10;
   endfunction

   // Code point spread over the one-, two- and three-byte forms and their edges
   function automatic logic [15:0] pick_code();
      case ($urandom_range(0, 4))
         0: return 16'($urandom_range(0, 16'h007f));
         1: return 16'($urandom_range(16'h0080, 16'h07ff));
         2: return 16'($urandom_range(16'h0800, 16'hffff));
         3: return 16'($urandom_range(16'hd800, 16'hdfff));
         default: begin
            case ($urandom_range(0, 5))
               0: return 16'h0000;
               1: return 16'h007f;
               2: return 16'h0080;
               3: return 16'h07ff;
               4: return 16'h0800;
               default: return 16'hffff;
            endcase
         end
      endcase
   endfunction

   // One string: mostly well-formed segments, some broken or cut-off escapes
   task automatic add_random_string();
      int          segs;
      int          kind;
      int          k;
      logic [15:0] code;
      logic [7:0]  b;
      logic        cut;
      segs = $urandom_range(1, 8);
      cut  = 1'b0;
      for (int s = 0; s < segs && !cut; s++) begin
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            do b = 8'($urandom); while (b == jsu_pkg::CHR_BSLASH);
            push_byte(b, 1'b0);
         end else if (kind < 65) begin
            push_byte(jsu_pkg::CHR_BSLASH, 1'b0);
            case ($urandom_range(0, 6))
               0: b = jsu_pkg::CHR_LOWER_B;
               1: b = jsu_pkg::CHR_LOWER_F;
               2: b = jsu_pkg::CHR_LOWER_N;
               3: b = jsu_pkg::CHR_LOWER_R;
               4: b = jsu_pkg::CHR_LOWER_T;
               default: begin
                  do b = 8'($urandom); while (b == jsu_pkg::CHR_LOWER_U);
               end
            endcase
            push_byte(b, 1'b0);
         end else if (kind < 92) begin
            push_byte(jsu_pkg::CHR_BSLASH, 1'b0);
            push_byte(jsu_pkg::CHR_LOWER_U, 1'b0);
            code = pick_code();
            for (int i = 3; i >= 0; i--) push_byte(hex_char(code[i*4 +: 4]), 1'b0);
         end else begin
            push_byte(jsu_pkg::CHR_BSLASH, 1'b0);
            push_byte(jsu_pkg::CHR_LOWER_U, 1'b0);
            k = $urandom_range(0, 3);
            repeat (k) push_byte(hex_char(4'($urandom)), 1'b0);
            if ($urandom_range(0, 1)) begin
               do b = 8'($urandom); while (is_hex(b));
               push_byte(b, 1'b0);
            end else begin
               cut = 1'b1;
            end
         end
      end
      // Occasionally finish on a lone backslash
      if (!cut && $urandom_range(0, 19) == 0) push_byte(jsu_pkg::CHR_BSLASH, 1'b0);
      raw_q[raw_q.size() - 1].last_byte = 1'b1;
      string_total++;
   endtask

   // Receiver: switch between no stall, random stall and a regular stall
   int stall_mode = 0;
   int stall_span = 0;
   int stall_tick = 0;
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_span = $urandom_range(20, 80);
      end else begin
         stall_span--;
      end
      stall_tick++;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 2) == 0);
         default: rsp_stall <= (stall_tick % 3 == 0);
      endcase
   end

   // Watchdog: end the run when no transfer happens for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int idx;
      int burst;
      int gap;

      // Directed strings: byte extremes, short escapes, UTF-8 forms, error cases
      push_byte(8'h00, 1'b0);
      push_byte(8'hff, 1'b1);
      push_text("\\b\\f\\n\\r\\t\\q");
      push_text("\\u00e9");
      push_text("\\uFfFf");
      push_text("\\");
      push_text("\\u1Gab");
      push_text("\\u12");
      push_text("\\uz");
      push_text("\\u");

      while (raw_q.size() < TOTAL_BYTES) begin
         add_random_string();
         if (pause_at < 0 && raw_q.size() >= TOTAL_BYTES / 2)
            pause_at = raw_q.size();
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Send in bursts with random gaps
      idx = 0;
      while (idx < raw_q.size()) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && idx < raw_q.size()) begin
            if (idx == pause_at) begin
               // Hold off until every decoded byte so far has come back
               req_valid <= 1'b0;
               do @(negedge clock); while (pending != 0);
               @(posedge clock);
            end
            req_valid <= 1'b1;
            req_data  <= raw_q[idx];
            do @(posedge clock); while (req_stall);
            idx++;
            burst--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      // Drain, then allow a few cycles for stray transfers
      do @(negedge clock); while (pending != 0);
      repeat (8) @(posedge clock);

      $display("summary: %0d raw bytes in %0d strings, %0d decoded results checked",
               raw_q.size(), string_total, checked);
      $display("summary: short escapes, 1/2/3-byte UTF-8, bad and cut-off escapes covered");
      if (mismatches == 0 && pending == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/jsu_pkg.sv
rtl/jsu_decode.sv
rtl/jsu_emit.sv
rtl/json_string_unescape_utf8.sv
sim/unescape_checker.sv
sim/tb.sv
